[design/sprite_quad_affine_setup_assert.svh]
// Assertion macros shared by the sprite quad setup modules.
`ifndef SPRITE_QUAD_AFFINE_SETUP_ASSERT_SVH
`define SPRITE_QUAD_AFFINE_SETUP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SQA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SQA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sqa_pkg.sv]
// Shared types and constants of the sprite quad setup block.
package sqa_pkg;

  // Widths of internal position terms
  localparam int POS_W = 28;
  localparam int OFF_W = 25;
  localparam int VTX_W = 20;
  localparam int TEX_W = 16;
  localparam int NUM_W = 13;

  // Texture divider: one quotient bit per stage
  localparam int DIV_STEPS = 17;
  // Position values join the divider timing after the multiply and position stages
  localparam int POS_DLY = DIV_STEPS - 2;

  // Request queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_SCALE_X   = 3'd0;
  localparam logic [2:0] REG_SCALE_Y   = 3'd1;
  localparam logic [2:0] REG_SPIVOT_X  = 3'd2;
  localparam logic [2:0] REG_SPIVOT_Y  = 3'd3;
  localparam logic [2:0] REG_RPIVOT_X  = 3'd4;
  localparam logic [2:0] REG_RPIVOT_Y  = 3'd5;
  localparam logic [2:0] REG_ROT_ANGLE = 3'd6;

  // One sprite request, with the per-sprite right and bottom edges added
  typedef struct packed {
    logic signed [15:0]      dest_x;
    logic signed [15:0]      dest_y;
    logic [11:0]             src_x;
    logic [11:0]             src_y;
    logic [11:0]             src_w;
    logic [11:0]             src_h;
    logic [12:0]             tex_width;
    logic [12:0]             tex_height;
    logic                    use_affine;
    logic signed [POS_W-1:0] xr;
    logic signed [POS_W-1:0] yb;
  } req_t;

  // Values derived from the configuration registers
  typedef struct packed {
    logic signed [15:0]      scale_x;
    logic signed [15:0]      scale_y;
    logic signed [15:0]      scale_pivot_x;
    logic signed [15:0]      scale_pivot_y;
    logic signed [OFF_W-1:0] ox;
    logic signed [OFF_W-1:0] oy;
    logic signed [POS_W-1:0] xl;
    logic signed [POS_W-1:0] yt;
    logic signed [15:0]      sin_a;
    logic signed [15:0]      cos_a;
  } geom_t;

  // Per-vertex tag that rides along the back pipeline
  typedef struct packed {
    logic       valid;
    logic [1:0] corner;
  } meta_t;

endpackage

[design/sqa_fifo.sv]
// Short request queue between the front and back parts.
`include "sprite_quad_affine_setup_assert.svh"
module sqa_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sqa_pkg::req_t push_req,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sqa_pkg::req_t head_req
);
  import sqa_pkg::*;

  req_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full       = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_req   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_req;
  end

  `SQA_ASSERT_NOW(a_fifo_bound, 1'b1, count <= FIFO_CNT_W'(FIFO_DEPTH), "queue overfilled")
  `SQA_ASSERT_NEXT(a_fifo_pop_only_filled, pop && !push && count == FIFO_CNT_W'(1),
    !head_valid, "queue count lost track")

endmodule

[design/sqa_front.sv]
// Front part: takes requests, computes the scaled right and bottom edges, queues them.
module sqa_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sqa_pkg::req_t  in_req,
  input  logic           accept_ok,
  input  sqa_pkg::geom_t geom,
  input  logic           pop,
  output logic           head_valid,
  output sqa_pkg::req_t  head_req
);
  import sqa_pkg::*;

  logic               a_v;
  req_t               a_req;
  logic               b_v;
  req_t               b_req;
  logic signed [33:0] b_xprod;
  logic signed [33:0] b_yprod;
  logic signed [17:0] xd;
  logic signed [17:0] yd;
  logic signed [33:0] xrnd;
  logic signed [33:0] yrnd;
  logic               a_ready;
  logic               b_ready;
  logic               fifo_full;
  logic               push;
  logic               in_xfer;
  req_t               push_req;

  assign push     = b_v && !fifo_full;
  assign b_ready  = !b_v || !fifo_full;
  assign a_ready  = !a_v || b_ready;
  assign in_ready = a_ready && accept_ok;
  assign in_xfer  = in_valid && in_ready;

  // Edge offsets in Q.4 relative to the scaling pivot
  assign xd = $signed({2'b00, a_req.src_w, 4'b0000}) - 18'(geom.scale_pivot_x);
  assign yd = $signed({2'b00, a_req.src_h, 4'b0000}) - 18'(geom.scale_pivot_y);

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      if (a_ready) a_v <= in_xfer;
      if (b_ready) b_v <= a_v;
    end
  end

  // Stage payloads: register, then scale products
  always_ff @(posedge clk) begin
    if (in_xfer) a_req <= in_req;
    if (b_ready && a_v) begin
      b_req   <= a_req;
      b_xprod <= xd * geom.scale_x;
      b_yprod <= yd * geom.scale_y;
    end
  end

  // Round half up, add pivot back, shift by the centre offset
  assign xrnd = b_xprod + 34'sd128;
  assign yrnd = b_yprod + 34'sd128;
  always_comb begin
    push_req    = b_req;
    push_req.xr = POS_W'($signed(xrnd[33:8])) + POS_W'(geom.scale_pivot_x)
                  - POS_W'(geom.ox);
    push_req.yb = POS_W'($signed(yrnd[33:8])) + POS_W'(geom.scale_pivot_y)
                  - POS_W'(geom.oy);
  end

  sqa_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_req   (push_req),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

endmodule

[design/sqa_div.sv]
// Pipelined texture coordinate divider: (num << 14) / den, rounded and saturated.
module sqa_div (
  input  logic        clk,
  input  logic        en,
  input  logic [12:0] num,
  input  logic [12:0] den,
  output logic [15:0] coord
);
  import sqa_pkg::*;

  logic [12:0]          rem [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo [DIV_STEPS];
  logic [DIV_STEPS-1:0] nb  [DIV_STEPS];
  logic [12:0]          dv  [DIV_STEPS];
  logic                 sat [DIV_STEPS];
  logic [DIV_STEPS:0]   rnd;

  // Quotient >= 2^17 happens exactly when num >= 4*den; zero den saturates too
  logic                 sat_in;
  assign sat_in = (den == '0) || ({2'b00, num} >= {den, 2'b00});

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [12:0]          pr;
    logic [DIV_STEPS-1:0] pq;
    logic [DIV_STEPS-1:0] pn;
    logic [12:0]          pd;
    logic                 ps;
    logic [13:0]          sh;
    logic [13:0]          df;
    logic                 ge;

    if (j == 0) begin : g_first
      assign pr = {2'b00, num[12:2]};
      assign pq = '0;
      assign pn = {num[1:0], 15'd0};
      assign pd = den;
      assign ps = sat_in;
    end else begin : g_next
      assign pr = rem[j-1];
      assign pq = quo[j-1];
      assign pn = nb[j-1];
      assign pd = dv[j-1];
      assign ps = sat[j-1];
    end

    // One restoring step
    assign sh = {pr, pn[DIV_STEPS-1]};
    assign ge = (sh >= {1'b0, pd});
    assign df = sh - {1'b0, pd};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? df[12:0] : sh[12:0];
        quo[j] <= {pq[DIV_STEPS-2:0], ge};
        nb[j]  <= {pn[DIV_STEPS-2:0], 1'b0};
        dv[j]  <= pd;
        sat[j] <= ps;
      end
    end
  end

  // Half-up rounding of the last bit, then clamp
  assign rnd   = ({1'b0, quo[DIV_STEPS-1]} + (DIV_STEPS+1)'(1)) >> 1;
  assign coord = (sat[DIV_STEPS-1] || rnd[DIV_STEPS:TEX_W] != '0) ? '1 : rnd[TEX_W-1:0];

endmodule

[design/sqa_back.sv]
// Back part: sequences four corners per request, rotates them in affine mode, divides, drives the result.
`include "sprite_quad_affine_setup_assert.svh"
module sqa_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  sqa_pkg::req_t      head_req,
  output logic               pop,
  input  sqa_pkg::geom_t     geom,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         corner,
  output logic signed [19:0] vertex_x,
  output logic signed [19:0] vertex_y,
  output logic [15:0]        tex_u,
  output logic [15:0]        tex_v,
  output logic               last
);
  import sqa_pkg::*;

  logic                    en;
  logic                    issue;
  logic [1:0]              k;

  // Issue stage
  logic                    s0_v;
  logic [1:0]              s0_corner;
  logic                    s0_aff;
  logic signed [POS_W-1:0] s0_x;
  logic signed [POS_W-1:0] s0_y;
  logic [VTX_W-1:0]        s0_px;
  logic [VTX_W-1:0]        s0_py;
  logic [VTX_W-1:0]        s0_cx;
  logic [VTX_W-1:0]        s0_cy;
  logic [NUM_W-1:0]        s0_nu;
  logic [NUM_W-1:0]        s0_nv;
  logic [NUM_W-1:0]        s0_du;
  logic [NUM_W-1:0]        s0_dv;

  // Multiply stage
  logic                    p1_aff;
  logic signed [43:0]      p1_xc;
  logic signed [43:0]      p1_ys;
  logic signed [43:0]      p1_xs;
  logic signed [43:0]      p1_yc;
  logic [VTX_W-1:0]        p1_px;
  logic [VTX_W-1:0]        p1_py;
  logic [VTX_W-1:0]        p1_cx;
  logic [VTX_W-1:0]        p1_cy;

  // Position stage and alignment line
  logic signed [44:0]      sum_x;
  logic signed [44:0]      sum_y;
  logic [VTX_W-1:0]        p2_x;
  logic [VTX_W-1:0]        p2_y;
  logic [VTX_W-1:0]        pxl [POS_DLY];
  logic [VTX_W-1:0]        pyl [POS_DLY];
  meta_t                   ml  [DIV_STEPS];
  logic [TEX_W-1:0]        u_q;
  logic [TEX_W-1:0]        v_q;

  assign en    = !out_valid || out_ready;
  assign issue = head_valid && en;
  assign pop   = issue && (k == CORNER_LAST);

  // Corner counter and issue valid
  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= head_valid;
      if (issue) k <= k + 1'b1;
    end
  end

  // Corner selection: k[0] picks right, k[1] picks bottom
  always_ff @(posedge clk) begin
    if (en) begin
      s0_corner <= k;
      s0_aff    <= head_req.use_affine;
      s0_x      <= k[0] ? head_req.xr : geom.xl;
      s0_y      <= k[1] ? head_req.yb : geom.yt;
      s0_px     <= VTX_W'(head_req.dest_x) - VTX_W'(8)
                   + (k[0] ? {4'b0000, head_req.src_w, 4'b0000} : '0);
      s0_py     <= VTX_W'(head_req.dest_y) - VTX_W'(8)
                   + (k[1] ? {4'b0000, head_req.src_h, 4'b0000} : '0);
      s0_cx     <= VTX_W'(head_req.dest_x) + VTX_W'(geom.ox) - VTX_W'(8);
      s0_cy     <= VTX_W'(head_req.dest_y) + VTX_W'(geom.oy) - VTX_W'(8);
      s0_nu     <= k[0] ? NUM_W'(head_req.src_x) + NUM_W'(head_req.src_w)
                        : NUM_W'(head_req.src_x);
      s0_nv     <= k[1] ? NUM_W'(head_req.src_y) + NUM_W'(head_req.src_h)
                        : NUM_W'(head_req.src_y);
      s0_du     <= head_req.tex_width;
      s0_dv     <= head_req.tex_height;
    end
  end

  // Rotation products
  always_ff @(posedge clk) begin
    if (en) begin
      p1_aff <= s0_aff;
      p1_xc  <= s0_x * geom.cos_a;
      p1_ys  <= s0_y * geom.sin_a;
      p1_xs  <= s0_x * geom.sin_a;
      p1_yc  <= s0_y * geom.cos_a;
      p1_px  <= s0_px;
      p1_py  <= s0_py;
      p1_cx  <= s0_cx;
      p1_cy  <= s0_cy;
    end
  end

  // Round half up by 2^14 and add the origin; only the low 20 bits survive
  assign sum_x = 45'(p1_xc) - 45'(p1_ys) + 45'sd8192;
  assign sum_y = 45'(p1_xs) + 45'(p1_yc) + 45'sd8192;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_x <= p1_aff ? sum_x[33:14] + p1_cx : p1_px;
      p2_y <= p1_aff ? sum_y[33:14] + p1_cy : p1_py;
    end
  end

  // Delay lines that line positions and tags up with the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      pxl[0] <= p2_x;
      pyl[0] <= p2_y;
      for (int j = 1; j < POS_DLY; j++) begin
        pxl[j] <= pxl[j-1];
        pyl[j] <= pyl[j-1];
      end
    end
  end

  // Tag line: valid bits reset, corners just follow
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIV_STEPS; j++) ml[j].valid <= 1'b0;
    end else if (en) begin
      ml[0].valid <= s0_v;
      for (int j = 1; j < DIV_STEPS; j++) ml[j].valid <= ml[j-1].valid;
    end
    if (en) begin
      ml[0].corner <= s0_corner;
      for (int j = 1; j < DIV_STEPS; j++) ml[j].corner <= ml[j-1].corner;
    end
  end

  sqa_div u_div_u (
    .clk   (clk),
    .en    (en),
    .num   (s0_nu),
    .den   (s0_du),
    .coord (u_q)
  );

  sqa_div u_div_v (
    .clk   (clk),
    .en    (en),
    .num   (s0_nv),
    .den   (s0_dv),
    .coord (v_q)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ml[DIV_STEPS-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      corner   <= ml[DIV_STEPS-1].corner;
      vertex_x <= $signed(pxl[POS_DLY-1]);
      vertex_y <= $signed(pyl[POS_DLY-1]);
      tex_u    <= u_q;
      tex_v    <= v_q;
      last     <= (ml[DIV_STEPS-1].corner == CORNER_LAST);
    end
  end

  `SQA_ASSERT_NEXT(a_back_wrap, pop, k == '0, "corner count not back at zero after pop")
  `SQA_ASSERT_NEXT(a_back_hold, !en, $stable(s0_corner) && s0_v == $past(s0_v),
    "issue stage moved during stall")

endmodule

[design/sprite_quad_affine_setup.sv]
// Sprite quad setup top level: config registers, derived terms, sine ROM, front and back.
// With no stall, a request passes the front stages and queue, then the back issue stage, dividers and result register.
// Throughput: one vertex per cycle while out_ready holds, four vertices per sprite from the corner sequencer.
// Texture coordinates come from two 17-stage dividers, one quotient bit per stage.
// Reset: registers return to scale 256, pivots and angle 0; queue and pipeline empty.
// After each configuration transfer the settle counter holds in_ready low while derived terms update.
`include "sprite_quad_affine_setup_assert.svh"
module sprite_quad_affine_setup #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] dest_x,
  input  logic signed [15:0] dest_y,
  input  logic [11:0]        src_x,
  input  logic [11:0]        src_y,
  input  logic [11:0]        src_w,
  input  logic [11:0]        src_h,
  input  logic [12:0]        tex_width,
  input  logic [12:0]        tex_height,
  input  logic               use_affine,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         corner,
  output logic signed [19:0] vertex_x,
  output logic signed [19:0] vertex_y,
  output logic [15:0]        tex_u,
  output logic [15:0]        tex_v,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import sqa_pkg::*;

  localparam int     IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef logic [31:0] trig_rom_t [SINE_TABLE_DEPTH];

  function automatic longint to_q14(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 64'sd32768) >>> 16;
    return (v < 0) ? -m : m;
  endfunction

  // Sine/cosine table, {sin, cos} in Q1.14, from a fixed-point Taylor series
  function automatic trig_rom_t build_trig();
    trig_rom_t rom;
    longint    q4;
    longint    quad;
    longint    rm;
    longint    a;
    longint    a2;
    longint    t;
    longint    s;
    longint    c;
    longint    sn;
    longint    cs;
    for (int n = 0; n < SINE_TABLE_DEPTH; n++) begin
      q4   = longint'(n) * 4;
      quad = q4 / SINE_TABLE_DEPTH;
      rm   = q4 % SINE_TABLE_DEPTH;
      a    = (rm * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      a2   = (a * a) >>> 30;
      s = a;
      t = a;
      t = ((t * a2) >>> 30) / 6;   s = s - t;
      t = ((t * a2) >>> 30) / 20;  s = s + t;
      t = ((t * a2) >>> 30) / 42;  s = s - t;
      t = ((t * a2) >>> 30) / 72;  s = s + t;
      t = ((t * a2) >>> 30) / 110; s = s - t;
      c = ONE_Q30;
      t = ONE_Q30;
      t = ((t * a2) >>> 30) / 2;   c = c - t;
      t = ((t * a2) >>> 30) / 12;  c = c + t;
      t = ((t * a2) >>> 30) / 30;  c = c - t;
      t = ((t * a2) >>> 30) / 56;  c = c + t;
      t = ((t * a2) >>> 30) / 90;  c = c - t;
      t = ((t * a2) >>> 30) / 132; c = c + t;
      s = to_q14(s);
      c = to_q14(c);
      case (quad % 4)
        0:       begin sn = s;  cs = c;  end
        1:       begin sn = c;  cs = -s; end
        2:       begin sn = -s; cs = -c; end
        default: begin sn = -c; cs = s;  end
      endcase
      rom[n] = {16'(sn), 16'(cs)};
    end
    return rom;
  endfunction

  localparam trig_rom_t TRIG = build_trig();

  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic signed [15:0] scale_pivot_x;
  logic signed [15:0] scale_pivot_y;
  logic signed [15:0] rotate_pivot_x;
  logic signed [15:0] rotate_pivot_y;
  logic [15:0]        rotate_angle;
  logic [1:0]         settle;
  logic               cfg_xfer;

  logic signed [16:0] dpx;
  logic signed [16:0] dpy;
  logic signed [16:0] npx;
  logic signed [16:0] npy;
  logic signed [32:0] ox_prod;
  logic signed [32:0] oy_prod;
  logic signed [32:0] xl_prod;
  logic signed [32:0] yt_prod;
  logic signed [32:0] ox_rnd;
  logic signed [32:0] oy_rnd;
  logic signed [32:0] xl_rnd;
  logic signed [32:0] yt_rnd;
  logic signed [OFF_W-1:0] ox_c;
  logic signed [OFF_W-1:0] oy_c;
  logic [16+IDX_W-1:0] ang_prod;
  logic [IDX_W-1:0]    ang_idx;
  logic [31:0]         trig_q;
  geom_t               geom;
  req_t                in_req;
  logic                head_valid;
  req_t                head_req;
  logic                pop;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x        <= 16'sd256;
      scale_y        <= 16'sd256;
      scale_pivot_x  <= '0;
      scale_pivot_y  <= '0;
      rotate_pivot_x <= '0;
      rotate_pivot_y <= '0;
      rotate_angle   <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_SCALE_X:   scale_x        <= $signed(cfg_data);
        REG_SCALE_Y:   scale_y        <= $signed(cfg_data);
        REG_SPIVOT_X:  scale_pivot_x  <= $signed(cfg_data);
        REG_SPIVOT_Y:  scale_pivot_y  <= $signed(cfg_data);
        REG_RPIVOT_X:  rotate_pivot_x <= $signed(cfg_data);
        REG_RPIVOT_Y:  rotate_pivot_y <= $signed(cfg_data);
        REG_ROT_ANGLE: rotate_angle   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off requests while derived terms catch up with a write
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= '0;
    end else if (cfg_xfer) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  // Scale products for the left/top edges and the centre offset
  assign dpx = 17'(rotate_pivot_x) - 17'(scale_pivot_x);
  assign dpy = 17'(rotate_pivot_y) - 17'(scale_pivot_y);
  assign npx = 17'sd0 - 17'(scale_pivot_x);
  assign npy = 17'sd0 - 17'(scale_pivot_y);

  always_ff @(posedge clk) begin
    ox_prod <= dpx * scale_x;
    oy_prod <= dpy * scale_y;
    xl_prod <= npx * scale_x;
    yt_prod <= npy * scale_y;
  end

  // Angle to table index, registered ROM read
  assign ang_prod = (16+IDX_W)'(rotate_angle) * (16+IDX_W)'(SINE_TABLE_DEPTH);
  assign ang_idx  = ang_prod[16+IDX_W-1:16];

  always_ff @(posedge clk) begin
    trig_q <= TRIG[ang_idx];
  end

  // Rounded offsets and edges
  assign ox_rnd = ox_prod + 33'sd128;
  assign oy_rnd = oy_prod + 33'sd128;
  assign xl_rnd = xl_prod + 33'sd128;
  assign yt_rnd = yt_prod + 33'sd128;
  assign ox_c   = $signed(ox_rnd[32:8]);
  assign oy_c   = $signed(oy_rnd[32:8]);

  always_ff @(posedge clk) begin
    geom.scale_x       <= scale_x;
    geom.scale_y       <= scale_y;
    geom.scale_pivot_x <= scale_pivot_x;
    geom.scale_pivot_y <= scale_pivot_y;
    geom.ox            <= ox_c;
    geom.oy            <= oy_c;
    geom.xl            <= POS_W'($signed(xl_rnd[32:8])) + POS_W'(scale_pivot_x)
                          - POS_W'(ox_c);
    geom.yt            <= POS_W'($signed(yt_rnd[32:8])) + POS_W'(scale_pivot_y)
                          - POS_W'(oy_c);
    geom.sin_a         <= $signed(trig_q[31:16]);
    geom.cos_a         <= $signed(trig_q[15:0]);
  end

  // Pack the request
  always_comb begin
    in_req            = '0;
    in_req.dest_x     = dest_x;
    in_req.dest_y     = dest_y;
    in_req.src_x      = src_x;
    in_req.src_y      = src_y;
    in_req.src_w      = src_w;
    in_req.src_h      = src_h;
    in_req.tex_width  = tex_width;
    in_req.tex_height = tex_height;
    in_req.use_affine = use_affine;
  end

  sqa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .accept_ok  (settle == '0),
    .geom       (geom),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  sqa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_req   (head_req),
    .pop        (pop),
    .geom       (geom),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .corner     (corner),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .tex_u      (tex_u),
    .tex_v      (tex_v),
    .last       (last)
  );

  `SQA_ASSERT_NEXT(a_top_settle, cfg_xfer, !in_ready, "request taken right after a config write")
  `SQA_ASSERT_NOW(a_top_out_last, out_valid, last == (corner == CORNER_LAST),
    "last flag disagrees with corner")

endmodule

[dv/sprite_quad_affine_setup_tb.sv]
// Self-checking testbench for the sprite quad setup block: random and directed sprites.
module sprite_quad_affine_setup_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sqa_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q30 = 64'd1073741824;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct {
    logic signed [15:0] dest_x, dest_y;
    logic [11:0] src_x, src_y, src_w, src_h;
    logic [12:0] tex_width, tex_height;
    logic use_affine;
  } sprite_t;

  typedef struct {
    logic [1:0] corner;
    logic [19:0] vx, vy;
    logic [15:0] u, v;
    logic last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] dest_x = '0, dest_y = '0;
  logic [11:0] src_x = '0, src_y = '0, src_w = '0, src_h = '0;
  logic [12:0] tex_width = '0, tex_height = '0;
  logic use_affine = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] corner;
  logic signed [19:0] vertex_x, vertex_y;
  logic [15:0] tex_u, tex_v;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sprite_t pending_sprites[$];
  vertex_t expected_vertices[$];
  logic [15:0] shadow_regs[7];
  int errors = 0;
  int sprites_sent = 0;
  int vertices_seen = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit tx_pause = 1'b0;
  bit in_fire = 1'b0;
  int rx_hold_req = 0;
  int rx_hold_cnt = 0;
  int quiet_cycles = 0;

  sprite_quad_affine_setup #(.SINE_TABLE_DEPTH(TABLE_DEPTH)) DUT (.*);

  always #10 clk = ~clk;

  // Half-up rounding of v / 2^n
  function automatic longint round_half_up(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint q30_to_q14(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (1 << 15)) >> 16;
    return (v < 0) ? -m : m;
  endfunction

  // Sine/cosine table entry k, Q1.14, built by a truncated Taylor series
  task automatic trig_entry(input longint k, output longint sn, output longint cs);
    longint q4, quad, rem, a, a2, t, s_sum, c_sum;
    q4 = k * 4;
    quad = q4 / TABLE_DEPTH;
    rem = q4 % TABLE_DEPTH;
    a = (rem * HALF_PI_Q30) / TABLE_DEPTH;
    a2 = (a * a) >> 30;
    t = a;
    s_sum = a;
    for (int i = 2; i <= 10; i += 2) begin
      t = ((t * a2) >> 30) / (i * (i + 1));
      s_sum = ((i / 2) & 1) ? s_sum - t : s_sum + t;
    end
    t = ONE_Q30;
    c_sum = ONE_Q30;
    for (int i = 1; i <= 11; i += 2) begin
      t = ((t * a2) >> 30) / (i * (i + 1));
      c_sum = (((i + 1) / 2) & 1) ? c_sum - t : c_sum + t;
    end
    s_sum = q30_to_q14(s_sum);
    c_sum = q30_to_q14(c_sum);
    case (quad & 3)
      0: begin sn = s_sum; cs = c_sum; end
      1: begin sn = c_sum; cs = -s_sum; end
      2: begin sn = -s_sum; cs = -c_sum; end
      default: begin sn = -c_sum; cs = s_sum; end
    endcase
  endtask

  // Q2.14 texture coordinate, half up, saturated
  function automatic logic [15:0] texel_to_uv(longint num, longint den);
    longint q;
    if (den == 0) return 16'hFFFF;
    q = (((num << 15) / den) + 1) >> 1;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic longint scale_about(longint c, longint pivot, longint scale);
    return round_half_up((c - pivot) * scale, 8) + pivot;
  endfunction

  // Work out the four corner vertices of one sprite
  task automatic predict_quad(input sprite_t s);
    longint px[4], py[4];
    longint scx, scy, spx, spy, rpx, rpy, ox, oy, xl, xr, yt, yb, cx, cy, x, y, sn, cs;
    logic [15:0] u0, u1, v0, v1;
    vertex_t vt;
    u0 = texel_to_uv(s.src_x, s.tex_width);
    u1 = texel_to_uv(longint'(s.src_x) + s.src_w, s.tex_width);
    v0 = texel_to_uv(s.src_y, s.tex_height);
    v1 = texel_to_uv(longint'(s.src_y) + s.src_h, s.tex_height);
    if (!s.use_affine) begin
      for (int k = 0; k < 4; k++) begin
        px[k] = longint'(s.dest_x) - 8 + ((k & 1) ? longint'(s.src_w) * 16 : 0);
        py[k] = longint'(s.dest_y) - 8 + ((k & 2) ? longint'(s.src_h) * 16 : 0);
      end
    end else begin
      scx = $signed(shadow_regs[REG_SCALE_X]);
      scy = $signed(shadow_regs[REG_SCALE_Y]);
      spx = $signed(shadow_regs[REG_SPIVOT_X]);
      spy = $signed(shadow_regs[REG_SPIVOT_Y]);
      rpx = $signed(shadow_regs[REG_RPIVOT_X]);
      rpy = $signed(shadow_regs[REG_RPIVOT_Y]);
      ox = round_half_up((rpx - spx) * scx, 8);
      oy = round_half_up((rpy - spy) * scy, 8);
      xl = scale_about(0, spx, scx) - ox;
      xr = scale_about(longint'(s.src_w) * 16, spx, scx) - ox;
      yt = scale_about(0, spy, scy) - oy;
      yb = scale_about(longint'(s.src_h) * 16, spy, scy) - oy;
      cx = longint'(s.dest_x) + ox - 8;
      cy = longint'(s.dest_y) + oy - 8;
      trig_entry((longint'(shadow_regs[REG_ROT_ANGLE]) * TABLE_DEPTH) >> 16, sn, cs);
      for (int k = 0; k < 4; k++) begin
        x = (k & 1) ? xr : xl;
        y = (k & 2) ? yb : yt;
        px[k] = round_half_up(x * cs - y * sn, 14) + cx;
        py[k] = round_half_up(x * sn + y * cs, 14) + cy;
      end
    end
    for (int k = 0; k < 4; k++) begin
      vt.corner = k[1:0];
      vt.vx = px[k][19:0];
      vt.vy = py[k][19:0];
      vt.u = (k & 1) ? u1 : u0;
      vt.v = (k & 2) ? v1 : v0;
      vt.last = (k == 3);
      expected_vertices.push_back(vt);
    end
  endtask

  // Transfer tracking, prediction and checking, all on the rising edge
  always @(posedge clk) begin
    vertex_t exp_v;
    in_fire <= in_valid && in_ready;
    if (!rst && cfg_valid && cfg_ready && cfg_index < 7) shadow_regs[cfg_index] = cfg_data;
    if (!rst && in_valid && in_ready) begin
      predict_quad('{dest_x, dest_y, src_x, src_y, src_w, src_h,
                     tex_width, tex_height, use_affine});
      sprites_sent++;
    end
    if (!rst && out_valid && out_ready) begin
      vertices_seen++;
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected vertex corner=%0d x=%h y=%h", $realtime, corner,
                 vertex_x, vertex_y);
        errors++;
      end else begin
        exp_v = expected_vertices.pop_front();
        if (corner !== exp_v.corner || vertex_x !== exp_v.vx || vertex_y !== exp_v.vy ||
            tex_u !== exp_v.u || tex_v !== exp_v.v || last !== exp_v.last) begin
          $display("%0t: vertex mismatch expected c=%0d x=%h y=%h u=%h v=%h l=%b",
                   $realtime, exp_v.corner, exp_v.vx, exp_v.vy, exp_v.u, exp_v.v, exp_v.last);
          $display("%0t:                 actual   c=%0d x=%h y=%h u=%h v=%h l=%b",
                   $realtime, corner, vertex_x, vertex_y, tex_u, tex_v, last);
          errors++;
        end
      end
    end
  end

  // Sprite driver: holds the offer until transfer, idles at random
  always @(negedge clk) begin
    sprite_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      if (pending_sprites.size() != 0 && !tx_pause && $urandom_range(99) >= tx_idle_pct) begin
        s = pending_sprites.pop_front();
        in_valid <= 1'b1;
        dest_x <= s.dest_x;
        dest_y <= s.dest_y;
        src_x <= s.src_x;
        src_y <= s.src_y;
        src_w <= s.src_w;
        src_h <= s.src_h;
        tex_width <= s.tex_width;
        tex_height <= s.tex_height;
        use_affine <= s.use_affine;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Vertex receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (rx_hold_req != 0 && rx_hold_cnt == 0) begin
      rx_hold_cnt <= rx_hold_req;
      rx_hold_req <= 0;
      out_ready <= 1'b0;
    end else if (rx_hold_cnt != 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Block is idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (pending_sprites.size() != 0 || in_valid || expected_vertices.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic sprite_t random_sprite(bit well_formed, int affine_pct);
    sprite_t s;
    s.dest_x = 16'($urandom);
    s.dest_y = 16'($urandom);
    s.use_affine = ($urandom_range(99) < affine_pct);
    if (well_formed) begin
      s.tex_width = 13'($urandom_range(4096, 1));
      s.tex_height = 13'($urandom_range(4096, 1));
      s.src_x = 12'($urandom_range(s.tex_width - 1));
      s.src_y = 12'($urandom_range(s.tex_height - 1));
      s.src_w = 12'($urandom_range(s.tex_width - s.src_x > 4095 ? 4095
                                                                : s.tex_width - s.src_x));
      s.src_h = 12'($urandom_range(s.tex_height - s.src_y > 4095 ? 4095
                                                                 : s.tex_height - s.src_y));
    end else begin
      s.src_x = 12'($urandom);
      s.src_y = 12'($urandom);
      s.src_w = 12'($urandom);
      s.src_h = 12'($urandom);
      s.tex_width = 13'($urandom);
      s.tex_height = 13'($urandom);
    end
    return s;
  endfunction

  initial begin
    logic [15:0] cfg_sets[5][7];
    logic [15:0] r;
    shadow_regs = '{16'd256, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    cfg_sets = '{
      '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF},
      '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'd16384},
      '{16'd512, 16'd128, 16'd80, 16'd160, 16'd40, 16'd320, 16'd32768},
      '{16'd256, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle_pct = 26;
    rx_idle_pct = 52;

    // Directed: field extremes, zero and oversize textures, both modes at reset config
    pending_sprites.push_back('{16'sh0000, 16'sh0000, 12'd0, 12'd0, 12'd0, 12'd0,
                               13'd1, 13'd1, 1'b0});
    pending_sprites.push_back('{16'sh7FFF, 16'sh8000, 12'd4095, 12'd4095, 12'd4095,
                               12'd4095, 13'd4096, 13'd4096, 1'b0});
    pending_sprites.push_back('{16'sh8000, 16'sh7FFF, 12'd10, 12'd20, 12'd30, 12'd40,
                               13'd0, 13'd0, 1'b0});
    pending_sprites.push_back('{16'shFFFF, 16'sh0001, 12'd4095, 12'd0, 12'd4095, 12'd1,
                               13'd1, 13'd8191, 1'b0});
    pending_sprites.push_back('{16'sh0100, 16'sh0200, 12'd0, 12'd0, 12'd64, 12'd64,
                               13'd64, 13'd64, 1'b1});
    pending_sprites.push_back('{16'sh7FFF, 16'sh7FFF, 12'd4095, 12'd4095, 12'd4095,
                               12'd4095, 13'd1, 13'd1, 1'b1});
    pending_sprites.push_back('{16'sh8000, 16'sh8000, 12'd0, 12'd0, 12'd0, 12'd0,
                               13'd0, 13'd4096, 1'b1});
    pending_sprites.push_back('{16'sh5555, 16'shAAAA, 12'hAAA, 12'h555, 12'h555,
                               12'hAAA, 13'h0AAA, 13'h1555, 1'b0});
    wait_idle();

    // Unknown register index must leave everything unchanged
    write_reg(REG_NONE, 16'h1234);
    for (int i = 0; i < 6; i++) pending_sprites.push_back(random_sprite(1'b1, 100));
    wait_idle();

    // Each register setting followed by a burst of sprites
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin tx_idle_pct = 52; rx_idle_pct = 26; end
      if (p == 4) begin tx_idle_pct = 0; rx_idle_pct = 0; end
      for (int i = 0; i < 7; i++) begin
        r = (p < 5) ? cfg_sets[p][i] : 16'($urandom);
        if (p == 5 && (i == REG_SCALE_X || i == REG_SCALE_Y)) r = 16'($urandom_range(768, 64));
        write_reg(i[2:0], r);
      end
      for (int i = 0; i < 16; i++)
        pending_sprites.push_back(random_sprite($urandom_range(99) < 80, 75));
      // Long receiver hold-off while the sender keeps offering
      if (p == 3) rx_hold_req = 300;
      wait_idle();
    end

    // Sender pause until every vertex is back, then a final burst
    tx_pause = 1'b1;
    wait_idle();
    tx_pause = 1'b0;
    for (int i = 0; i < 8; i++) pending_sprites.push_back(random_sprite(1'b1, 50));
    wait_idle();

    $display("Covered %0d sprites (%0d vertices) in plain and affine modes", sprites_sent,
             vertices_seen);
    $display("over six register settings incl. scale, pivot and angle extremes.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
